/* hw/rtl/histogram_median_filter_unit_defines.svh */
// ---------------------------------------------------------------------------
// histogram median filter assertion macros
// concurrent assertion shorthands shared by the filter rtl
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define HISTOGRAM_MEDIAN_FILTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define HMF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hmf assertion failed");

// consequent holds in the same cycle as the antecedent
`define HMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmf assertion failed");

// consequent holds in the cycle after the antecedent
`define HMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmf assertion failed");

`else

`define HMF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define HMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/hmf_pkg.sv */
// ---------------------------------------------------------------------------
// hmf_pkg
// shared types, widths and codes of the histogram median filter
// ---------------------------------------------------------------------------
package hmf_pkg;

    localparam int GRAY_LEVELS = 256;
    localparam int GRAY_W      = 8;
    localparam int MASK_W      = 4;
    localparam int IMG_COL_W   = 11;
    localparam int ROW_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [GRAY_W-1:0] GRAY_LAST = GRAY_W'(GRAY_LEVELS - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // commands from the sequencer to the histogram unit
    typedef struct packed {
        logic              start;  // new window: drop forwarding, clear scan sum
        logic              inc;    // count one pixel into bin addr
        logic              scan;   // read bin addr into the running sum, zero it
        logic              clr;    // zero bin addr
        logic [GRAY_W-1:0] addr;
    } t_hist_ctl;

    typedef struct packed {
        logic              found;
        logic [GRAY_W-1:0] level;
    } t_hist_stat;

    // even sizes go up by one, then clip to the largest odd size allowed
    function automatic logic [MASK_W-1:0] eff_mask(input logic [MASK_W-1:0] m,
                                                   input logic [MASK_W-1:0] lim);
        logic [MASK_W-1:0] v;
        v = m[0] ? m : m + MASK_W'(1);
        if (v > lim) begin
            v = lim;
        end
        return v;
    endfunction

endpackage

/* hw/rtl/hmf_ram.sv */
// ---------------------------------------------------------------------------
// hmf_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module hmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/hmf_hist.sv */
// ---------------------------------------------------------------------------
// hmf_hist
// 256-bin histogram with read-modify-write counting and a median scan
// ---------------------------------------------------------------------------
module hmf_hist #(
    parameter int MAX_MASK = 9
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  hmf_pkg::t_hist_ctl                       i_ctl,
    input  logic [$clog2(MAX_MASK*MAX_MASK+1)-1:0]   i_need,
    output hmf_pkg::t_hist_stat                      o_stat
);
    import hmf_pkg::*;

    localparam int HCW = $clog2(MAX_MASK * MAX_MASK + 1);

    logic              ram_we;
    logic [GRAY_W-1:0] ram_waddr;
    logic [HCW-1:0]    ram_wdata;
    logic [HCW-1:0]    ram_q;

    logic              r_p2_vld;
    logic [GRAY_W-1:0] r_p2_addr;
    logic              r_last_vld;
    logic [GRAY_W-1:0] r_last_addr;
    logic [HCW-1:0]    r_last_val;
    logic [HCW-1:0]    inc_base;
    logic [HCW-1:0]    inc_val;

    logic              r_sc_vld;
    logic [GRAY_W-1:0] r_sc_addr;
    logic [HCW-1:0]    r_acc;
    logic [HCW-1:0]    sum;
    logic              r_found;
    logic [GRAY_W-1:0] r_level;

    hmf_ram #(
        .WIDTH(HCW),
        .DEPTH(GRAY_LEVELS)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(i_ctl.addr),
        .o_rdata(ram_q)
    );

    // the previous write has not reached the read data yet
    assign inc_base = (r_last_vld && (r_last_addr == r_p2_addr)) ? r_last_val : ram_q;
    assign inc_val  = inc_base + HCW'(1);
    assign sum      = r_acc + ram_q;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_ctl.addr;
        ram_wdata = '0;
        if (i_ctl.scan || i_ctl.clr) begin
            ram_we = 1'b1;
        end else if (r_p2_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_p2_addr;
            ram_wdata = inc_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld   <= 1'b0;
            r_sc_vld   <= 1'b0;
            r_last_vld <= 1'b0;
            r_found    <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_p2_vld <= i_ctl.inc;
            r_sc_vld <= i_ctl.scan;
            if (i_ctl.start) begin
                r_last_vld <= 1'b0;
                r_found    <= 1'b0;
                r_acc      <= '0;
            end else begin
                if (r_p2_vld) begin
                    r_last_vld <= 1'b1;
                end
                if (r_sc_vld) begin
                    r_acc <= sum;
                    if (!r_found && (sum >= i_need)) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_addr <= i_ctl.addr;
        r_sc_addr <= i_ctl.addr;
        if (r_p2_vld) begin
            r_last_addr <= r_p2_addr;
            r_last_val  <= inc_val;
        end
        if (r_sc_vld && !r_found && (sum >= i_need)) begin
            r_level <= r_sc_addr;
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.level = r_level;

endmodule

/* hw/rtl/histogram_median_filter_unit.sv */
// ---------------------------------------------------------------------------
// histogram_median_filter_unit
// median filter over a raster-order gray image, one histogram per window
// ---------------------------------------------------------------------------
// usage:
//   pixels enter in raster order on the input channel (i_in_valid/o_in_ready).
//   a pixel that completes a window yields one transaction on the output
//   channel (o_out_valid/i_out_ready) with the median and the window centre;
//   border pixels yield nothing.
//   a pixel that completes no window leaves the block idle for the next one.
//   a window pixel holds o_in_ready low until its result is loaded: one line
//   store read a cycle feeds the mask_w*mask_h window pixels into the
//   histogram ram, then a scan over all 256 bins reads the running sum and
//   zeroes each bin for the next window.
//   the result sits in an output register; the next pixel is taken while it
//   waits, and a window that finishes before it is taken holds until then.
//   after reset a pass over all 256 bins clears the histogram with o_in_ready
//   low. config writes (i_cfg_we) go in any time the block is idle and
//   restart the frame at row 0, column 0.
// ---------------------------------------------------------------------------
`include "histogram_median_filter_unit_defines.svh"

module histogram_median_filter_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_MASK  = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hmf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [hmf_pkg::GRAY_W-1:0]        i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [hmf_pkg::GRAY_W-1:0]        o_median,
    output logic [hmf_pkg::ROW_W-1:0]         o_centre_row,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_centre_column,
    output logic                              o_last_of_frame
);
    import hmf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_MASK);
    localparam int LSD = MAX_MASK * MAX_WIDTH;
    localparam int AW  = $clog2(LSD);
    localparam int HCW = $clog2(MAX_MASK * MAX_MASK + 1);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > IMG_COL_W) ? $clog2(MAX_WIDTH + 1) : IMG_COL_W;
    localparam int PW  = 2 * MASK_W + 1;

    localparam logic [MASK_W-1:0] MASK_LIM =
        MASK_W'((MAX_MASK % 2 == 0) ? MAX_MASK - 1 : MAX_MASK);
    localparam logic [RW-1:0] RING_LAST = RW'(MAX_MASK - 1);
    localparam logic [WW-1:0] WIDTH_MAX = WW'(MAX_WIDTH);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_GATHER = 3'd2;
    localparam logic [2:0] S_DRAIN1 = 3'd3;
    localparam logic [2:0] S_DRAIN2 = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // configuration
    logic [MASK_W-1:0]    r_mask_w;
    logic [MASK_W-1:0]    r_mask_h;
    logic [IMG_COL_W-1:0] r_img_w;
    logic [ROW_W-1:0]     r_img_h;

    logic [MASK_W-1:0]    mw_eff;
    logic [MASK_W-1:0]    mh_eff;
    logic [WW-1:0]        w_ext;
    logic [WW-1:0]        w_clip;
    logic [CW-1:0]        last_col;
    logic [ROW_W-1:0]     last_row;

    // frame position
    logic [ROW_W-1:0]     r_row;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_ring;

    logic                 in_acc;
    logic                 win;
    logic [PW-1:0]        area;

    // sequencer
    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [GRAY_W-1:0]    r_cnt;
    logic [MASK_W-1:0]    r_k;
    logic [MASK_W-1:0]    r_j;
    logic [RW-1:0]        r_rd_ring;
    logic [CW-1:0]        r_rd_col;
    logic [CW-1:0]        r_win_col;
    logic [MASK_W-1:0]    r_mw;
    logic [MASK_W-1:0]    r_mh;
    logic [HCW-1:0]       r_need;
    logic [ROW_W-1:0]     r_crow;
    logic [CW-1:0]        r_ccol;
    logic                 r_last;
    logic                 row_end;
    logic                 win_end;

    // line store
    logic [AW-1:0]        ls_waddr;
    logic [AW-1:0]        ls_raddr;
    logic [GRAY_W-1:0]    ls_q;
    logic                 r_lq_vld;

    t_hist_ctl            hist_ctl;
    t_hist_stat           hist_stat;

    // output register
    logic                 out_load;
    logic                 r_out_vld;
    logic [GRAY_W-1:0]    r_median;
    logic [ROW_W-1:0]     r_out_row;
    logic [CW-1:0]        r_out_col;
    logic                 r_out_last;

    assign mw_eff   = eff_mask(r_mask_w, MASK_LIM);
    assign mh_eff   = eff_mask(r_mask_h, MASK_LIM);
    assign w_ext    = WW'(r_img_w);
    assign w_clip   = (w_ext == '0) ? WW'(1) : ((w_ext > WIDTH_MAX) ? WIDTH_MAX : w_ext);
    assign last_col = CW'(w_clip - WW'(1));
    assign last_row = (r_img_h == '0) ? '0 : r_img_h - ROW_W'(1);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign win        = (r_row >= ROW_W'(mh_eff - MASK_W'(1))) &&
                        (WW'(r_col) >= WW'(mw_eff - MASK_W'(1)));
    assign area       = PW'(mw_eff) * PW'(mh_eff);

    assign row_end = (r_j == r_mw - MASK_W'(1));
    assign win_end = row_end && (r_k == r_mh - MASK_W'(1));

    // configuration writes, any write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_w <= MASK_W'(9);
            r_mask_h <= MASK_W'(9);
            r_img_w  <= IMG_COL_W'(1024);
            r_img_h  <= ROW_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASK_WIDTH:   r_mask_w <= i_cfg_data[MASK_W-1:0];
                CFG_MASK_HEIGHT:  r_mask_h <= i_cfg_data[MASK_W-1:0];
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[IMG_COL_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[ROW_W-1:0];
                default:          r_img_h  <= r_img_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_ring <= '0;
        end else if (i_cfg_we) begin
            r_row  <= '0;
            r_col  <= '0;
            r_ring <= '0;
        end else if (in_acc) begin
            if (r_col == last_col) begin
                r_col <= '0;
                if (r_row == last_row) begin
                    r_row  <= '0;
                    r_ring <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_ring <= (r_ring == RING_LAST) ? '0 : r_ring + RW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line store: one ring row per image row
    assign ls_waddr = AW'(int'(r_ring) * MAX_WIDTH) + AW'(r_col);
    assign ls_raddr = AW'(int'(r_rd_ring) * MAX_WIDTH) + AW'(r_rd_col);

    hmf_ram #(
        .WIDTH(GRAY_W),
        .DEPTH(LSD)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(ls_waddr),
        .i_wdata(i_pixel),
        .i_raddr(ls_raddr),
        .o_rdata(ls_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_cnt == GRAY_LAST) n_state = S_IDLE;
            S_IDLE:   if (in_acc && win) n_state = S_GATHER;
            S_GATHER: if (win_end) n_state = S_DRAIN1;
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_SCAN;
            S_SCAN:   if (r_cnt == GRAY_LAST) n_state = S_FLUSH;
            S_FLUSH:  n_state = S_DONE;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_lq_vld <= 1'b0;
            r_k      <= '0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_lq_vld <= (r_state == S_GATHER);
            // bin counter wraps back to zero at the end of each pass
            if ((r_state == S_CLEAR) || (r_state == S_SCAN)) begin
                r_cnt <= r_cnt + GRAY_W'(1);
            end
            if (in_acc && win) begin
                r_k <= '0;
                r_j <= '0;
            end else if (r_state == S_GATHER) begin
                if (row_end) begin
                    r_j <= '0;
                    r_k <= r_k + MASK_W'(1);
                end else begin
                    r_j <= r_j + MASK_W'(1);
                end
            end
        end
    end

    // window walk: newest row first, right to left within a row
    always_ff @(posedge i_clk) begin
        if (in_acc && win) begin
            r_rd_ring <= r_ring;
            r_rd_col  <= r_col;
            r_win_col <= r_col;
            r_mw      <= mw_eff;
            r_mh      <= mh_eff;
            r_need    <= HCW'((area + PW'(1)) >> 1);
            r_crow    <= r_row - ROW_W'(mh_eff >> 1);
            r_ccol    <= r_col - CW'(mw_eff >> 1);
            r_last    <= (r_row == last_row) && (r_col == last_col);
        end else if (r_state == S_GATHER) begin
            if (row_end) begin
                r_rd_col  <= r_win_col;
                r_rd_ring <= (r_rd_ring == '0) ? RING_LAST : r_rd_ring - RW'(1);
            end else begin
                r_rd_col <= r_rd_col - CW'(1);
            end
        end
    end

    assign hist_ctl.start = in_acc && win;
    assign hist_ctl.inc   = r_lq_vld;
    assign hist_ctl.scan  = (r_state == S_SCAN);
    assign hist_ctl.clr   = (r_state == S_CLEAR);
    assign hist_ctl.addr  = r_lq_vld ? ls_q : r_cnt;

    hmf_hist #(
        .MAX_MASK(MAX_MASK)
    ) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (hist_ctl),
        .i_need (r_need),
        .o_stat (hist_stat)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_median   <= hist_stat.level;
            r_out_row  <= r_crow;
            r_out_col  <= r_ccol;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_median        = r_median;
    assign o_centre_row    = r_out_row;
    assign o_centre_column = r_out_col;
    assign o_last_of_frame = r_out_last;

    `HMF_ASSERT_IMPLY(a_gather_in_mask, i_clk, i_rst_n, r_state == S_GATHER, (r_k < r_mh) && (r_j < r_mw))
    `HMF_ASSERT_IMPLY(a_median_found, i_clk, i_rst_n, r_state == S_DONE, hist_stat.found)
    `HMF_ASSERT_ALWAYS(a_pos_in_image, i_clk, i_rst_n, (r_col <= last_col) && (r_row <= last_row))
    `HMF_ASSERT_NEXT(a_window_starts, i_clk, i_rst_n, in_acc && win, r_state == S_GATHER)

endmodule
